// File: design/scs_pkg.sv
`timescale 1ns / 1ps

package scs_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 8;
  localparam int K_W      = 4;

  // statistics widths
  localparam int MAX_SAMPLES = 4096;
  localparam int COUNT_W     = $clog2(MAX_SAMPLES) + 1;
  localparam int SUM_W       = SAMPLE_W + COUNT_W - 1;
  localparam int SQ_W        = 2 * SAMPLE_W + COUNT_W - 2;
  localparam int MEAN_W      = SAMPLE_W;
  localparam int DEV_W       = SAMPLE_W;
  localparam int MSQ_W       = 2 * SAMPLE_W - 1;
  localparam int PROD_W      = 2 * SAMPLE_W;

  // conversion widths
  localparam int SPAN_W  = DEV_W + K_W;
  localparam int BOUND_W = SPAN_W + 2;
  localparam int NUM_W   = SPAN_W + 1 + LEVEL_W;

  // shared divide / root unit
  localparam int ITER_W = SQ_W + 1;
  localparam int QUO_W  = MSQ_W;
  localparam int STEP_W = $clog2(QUO_W + 1);

  // configuration port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int IDX_W  = ADDR_W - 2;
  localparam logic [IDX_W-1:0] REG_SPREAD_SIGMAS = '0;
  localparam logic [K_W-1:0]   SPREAD_RESET      = K_W'(2);

  // item function codes
  localparam logic FUNC_ACCUM   = 1'b0;
  localparam logic FUNC_CONVERT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC_MUL,
    ST_ACC_ADD,
    ST_MEAN_GO,
    ST_MEAN_DIV,
    ST_MSQ_DIV,
    ST_VAR_MUL,
    ST_VAR,
    ST_ROOT,
    ST_CNV_MUL,
    ST_CNV_CMP,
    ST_CNV_DIV,
    ST_EMIT
  } st_t;

  typedef struct packed {
    logic              start;
    logic              sqrt_mode;
    logic [ITER_W-1:0] rem_init;
    logic [ITER_W-1:0] dvs_init;
    logic [STEP_W-1:0] steps;
  } iter_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] result;
  } iter_sts_t;

endpackage

// File: design/scs_in_if.sv
`timescale 1ns / 1ps

interface scs_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic signed [scs_pkg::SAMPLE_W-1:0] sample;
  logic                                last;

  modport source (output valid, func, sample, last, input ready);
  modport sink   (input valid, func, sample, last, output ready);
endinterface

// File: design/scs_out_if.sv
`timescale 1ns / 1ps

interface scs_out_if;
  logic                         valid;
  logic                         ready;
  logic [scs_pkg::LEVEL_W-1:0]  level;
  logic                         last_out;

  modport source (output valid, level, last_out, input ready);
  modport sink   (input valid, level, last_out, output ready);
endinterface

// File: design/scs_iter_unit.sv
`timescale 1ns / 1ps

// restoring divide and digit-by-digit square root, one bit per cycle
module scs_iter_unit (
  input  logic               clk,
  input  logic               rst,
  input  scs_pkg::iter_cmd_t cmd,
  output scs_pkg::iter_sts_t sts
);
  import scs_pkg::*;

  logic [ITER_W-1:0] rem;
  logic [ITER_W-1:0] dvs;
  logic [QUO_W-1:0]  quo;
  logic [STEP_W-1:0] cnt;
  logic              sqrt_mode;
  logic              busy;
  logic              done;

  logic [ITER_W-1:0] opb;
  logic [ITER_W:0]   diff;
  logic              ge;

  // shared subtract and compare
  always_comb begin
    opb  = sqrt_mode ? (ITER_W'(quo) | dvs) : dvs;
    diff = {1'b0, rem} - {1'b0, opb};
    ge   = !diff[ITER_W];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem       <= cmd.rem_init;
      dvs       <= cmd.dvs_init;
      quo       <= '0;
      cnt       <= cmd.steps;
      sqrt_mode <= cmd.sqrt_mode;
    end else if (busy) begin
      cnt <= cnt - STEP_W'(1);
      if (ge) begin
        rem <= diff[ITER_W-1:0];
      end
      if (sqrt_mode) begin
        quo <= ge ? ((quo >> 1) | dvs[QUO_W-1:0]) : (quo >> 1);
        dvs <= dvs >> 2;
      end else begin
        quo <= {quo[QUO_W-2:0], ge};
        dvs <= dvs >> 1;
      end
    end
  end

  assign sts.busy   = busy;
  assign sts.done   = done;
  assign sts.result = quo;

endmodule

// File: design/sigma_clip_contrast_stretch_top.sv
`timescale 1ns / 1ps

// channel   dir  beat fields                 handshake
// in_ch     in   func, sample, last          valid / ready
// out_ch    out  level, last_out             valid / ready
// apb       in   paddr, pwdata -> prdata     psel / penable, pready tied high
//
// accumulate beat: multiply, then add; the beat marked last adds a finalise
// (mean divide 16 steps, mean-square divide 31 steps, root 16 steps)
// convert beat: multiply and compare, then emit when clipped, or an 8-step divide first when scaled
// the divides and the root run on the shared one-bit-per-cycle divide / root unit
// rst is synchronous: statistics clear, spread_sigmas returns to 2
// a result waits in the output register; a new beat is taken meanwhile

module sigma_clip_contrast_stretch_top (
  input  logic                         clk,
  input  logic                         rst,
  scs_in_if.sink                       in_ch,
  scs_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [scs_pkg::ADDR_W-1:0]   paddr,
  input  logic [scs_pkg::DATA_W-1:0]   pwdata,
  output logic [scs_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import scs_pkg::*;

  function automatic logic [SAMPLE_W-1:0] mag16(input logic signed [SAMPLE_W-1:0] x);
    logic [SAMPLE_W-1:0] r;
    r = x[SAMPLE_W-1] ? SAMPLE_W'(-x) : SAMPLE_W'(x);
    return r;
  endfunction

  st_t state, state_next;

  logic [K_W-1:0]              spread_sigmas;
  logic [COUNT_W-1:0]          sample_count;
  logic signed [SUM_W-1:0]     sum_acc;
  logic [SQ_W-1:0]             square_acc;
  logic signed [MEAN_W-1:0]    mean_value;
  logic [DEV_W-1:0]            deviation_value;
  logic [MSQ_W-1:0]            msq;

  logic                        item_func;
  logic signed [SAMPLE_W-1:0]  item_sample;
  logic                        item_last;

  logic [PROD_W-1:0]           prod;
  logic [SAMPLE_W-1:0]         mul_a;
  logic [SAMPLE_W-1:0]         mul_b;

  logic [LEVEL_W-1:0]          level_r;
  logic                        out_valid;
  logic [LEVEL_W-1:0]          out_level;
  logic                        out_last;

  iter_cmd_t                   cmd;
  iter_sts_t                   sts;

  logic                        in_acc;
  logic                        cfg_wr;
  logic                        room;
  logic [SUM_W-1:0]            sum_mag;
  logic [MSQ_W-1:0]            var_val;

  logic [SPAN_W-1:0]           span;
  logic signed [BOUND_W-1:0]   lo;
  logic signed [BOUND_W-1:0]   hi;
  logic signed [BOUND_W-1:0]   v_ext;
  logic signed [BOUND_W-1:0]   v_off;
  logic [NUM_W-1:0]            num;
  logic                        clip_lo;
  logic                        clip_hi;

  scs_iter_unit u_iter (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts)
  );

  assign in_acc = in_ch.valid && in_ch.ready;
  assign room   = !out_valid || out_ch.ready;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_SPREAD_SIGMAS);
  assign prdata = (paddr[ADDR_W-1:2] == REG_SPREAD_SIGMAS) ? DATA_W'(spread_sigmas) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      spread_sigmas <= SPREAD_RESET;
    end else if (cfg_wr) begin
      spread_sigmas <= pwdata[K_W-1:0];
    end
  end

  // conversion bounds
  always_comb begin
    span    = prod[SPAN_W-1:0];
    lo      = BOUND_W'(mean_value) - BOUND_W'(span);
    hi      = BOUND_W'(mean_value) + BOUND_W'(span);
    v_ext   = BOUND_W'(item_sample);
    clip_lo = v_ext <= lo;
    clip_hi = v_ext >= hi;
    v_off   = v_ext - lo;
    num     = (NUM_W'(v_off[SPAN_W:0]) << LEVEL_W) - NUM_W'(v_off[SPAN_W:0]);
  end

  // finalise helpers
  always_comb begin
    sum_mag = sum_acc[SUM_W-1] ? SUM_W'(-sum_acc) : SUM_W'(sum_acc);
    var_val = ({1'b0, msq} > prod) ? (msq - prod[MSQ_W-1:0]) : '0;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_acc) begin
                     state_next = (in_ch.func == FUNC_CONVERT) ? ST_CNV_MUL : ST_ACC_MUL;
                   end
      ST_ACC_MUL:  state_next = ST_ACC_ADD;
      ST_ACC_ADD:  state_next = item_last ? ST_MEAN_GO : ST_IDLE;
      ST_MEAN_GO:  state_next = ST_MEAN_DIV;
      ST_MEAN_DIV: if (sts.done) begin
                     state_next = ST_MSQ_DIV;
                   end
      ST_MSQ_DIV:  if (sts.done) begin
                     state_next = ST_VAR_MUL;
                   end
      ST_VAR_MUL:  state_next = ST_VAR;
      ST_VAR:      state_next = ST_ROOT;
      ST_ROOT:     if (sts.done) begin
                     state_next = ST_IDLE;
                   end
      ST_CNV_MUL:  state_next = ST_CNV_CMP;
      ST_CNV_CMP:  state_next = (clip_lo || clip_hi) ? ST_EMIT : ST_CNV_DIV;
      ST_CNV_DIV:  if (sts.done) begin
                     state_next = ST_EMIT;
                   end
      ST_EMIT:     if (room) begin
                     state_next = ST_IDLE;
                   end
      default:     state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready   = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    cmd.start     = 1'b0;
    cmd.sqrt_mode = 1'b0;
    cmd.rem_init  = '0;
    cmd.dvs_init  = '0;
    cmd.steps     = '0;
    unique case (state)
      ST_IDLE:     in_ch.ready = 1'b1;
      ST_ACC_MUL:  begin
        mul_a = mag16(item_sample);
        mul_b = mag16(item_sample);
      end
      ST_MEAN_GO:  begin
        cmd.start    = 1'b1;
        cmd.rem_init = ITER_W'(sum_mag);
        cmd.dvs_init = ITER_W'(sample_count) << (MEAN_W - 1);
        cmd.steps    = STEP_W'(MEAN_W);
      end
      ST_MEAN_DIV: begin
        cmd.start    = sts.done;
        cmd.rem_init = ITER_W'(square_acc);
        cmd.dvs_init = ITER_W'(sample_count) << (QUO_W - 1);
        cmd.steps    = STEP_W'(QUO_W);
      end
      ST_VAR_MUL:  begin
        mul_a = mag16(mean_value);
        mul_b = mag16(mean_value);
      end
      ST_VAR:      begin
        cmd.start     = 1'b1;
        cmd.sqrt_mode = 1'b1;
        cmd.rem_init  = ITER_W'(var_val);
        cmd.dvs_init  = ITER_W'(1) << (2 * DEV_W - 2);
        cmd.steps     = STEP_W'(DEV_W);
      end
      ST_CNV_MUL:  begin
        mul_a = SAMPLE_W'(spread_sigmas);
        mul_b = deviation_value;
      end
      ST_CNV_CMP:  begin
        cmd.start    = !(clip_lo || clip_hi);
        cmd.rem_init = ITER_W'(num);
        cmd.dvs_init = ITER_W'(span) << LEVEL_W;
        cmd.steps    = STEP_W'(LEVEL_W);
      end
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // beat capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_func   <= in_ch.func;
      item_sample <= in_ch.sample;
      item_last   <= in_ch.last;
    end
  end

  // statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count    <= '0;
      sum_acc         <= '0;
      square_acc      <= '0;
      mean_value      <= '0;
      deviation_value <= '0;
    end else begin
      unique case (state)
        ST_ACC_ADD:  if (sample_count < COUNT_W'(MAX_SAMPLES)) begin
                       sample_count <= sample_count + COUNT_W'(1);
                       sum_acc      <= sum_acc + SUM_W'(item_sample);
                       square_acc   <= square_acc + SQ_W'(prod);
                     end
        ST_MEAN_DIV: if (sts.done) begin
                       mean_value <= sum_acc[SUM_W-1] ? MEAN_W'(-sts.result[MEAN_W-1:0])
                                                      : MEAN_W'(sts.result[MEAN_W-1:0]);
                     end
        ST_ROOT:     if (sts.done) begin
                       deviation_value <= sts.result[DEV_W-1:0];
                       sample_count    <= '0;
                       sum_acc         <= '0;
                       square_acc      <= '0;
                     end
        default:     ;
      endcase
    end
  end

  // mean of squares and level; at or below the low bound wins over the high one
  always_ff @(posedge clk) begin
    if (state == ST_MSQ_DIV && sts.done) begin
      msq <= sts.result;
    end
    if (state == ST_CNV_CMP) begin
      level_r <= clip_lo ? '0 : {LEVEL_W{1'b1}};
    end else if (state == ST_CNV_DIV && sts.done) begin
      level_r <= sts.result[LEVEL_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && room) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && room) begin
      out_level <= level_r;
      out_last  <= item_last && (item_func == FUNC_CONVERT);
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.level    = out_level;
  assign out_ch.last_out = out_last;

endmodule

// File: design/scs_checker.sv
`timescale 1ns / 1ps

module scs_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_func,
  input logic out_valid,
  input logic out_ready,
  input logic [scs_pkg::LEVEL_W-1:0] out_level
);
  import scs_pkg::*;

  // one beat at a time: ready drops after a beat is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a beat is in work");

  // a result never shows on the cycle after its beat is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_func == FUNC_CONVERT) |=> !$rose(out_valid))
    else $error("result appeared too early");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_level)))
    else $error("stalled result changed");

  // after reset the block is empty and ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

endmodule

bind sigma_clip_contrast_stretch_top scs_checker u_scs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_func   (in_ch.func),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_level (out_ch.level)
);

// File: verif/scs_level_checker.sv
`timescale 1ns / 1ps

module scs_level_checker
  import scs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  scs_in_if                 in_ch,
  scs_out_if                out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int unsigned       mismatches,
  output int unsigned       outstanding
);

  localparam int REPORT_MAX = 10;
  localparam int LEVEL_TOP  = 255;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               last_out;
  } level_beat_t;

  // levels still owed by the block, oldest first
  level_beat_t level_q[$];

  // shadow of the block's statistics and spread register
  logic [K_W-1:0]           spread;
  logic [COUNT_W-1:0]       count_acc;
  logic signed [SUM_W-1:0]  sum_acc;
  logic [SQ_W-1:0]          sq_acc;
  logic signed [MEAN_W-1:0] mean_val;
  logic [DEV_W-1:0]         dev_val;
  int unsigned              fail_count;

  // floor square root, built one result bit at a time
  function automatic u64_t root_floor(input u64_t x);
    u64_t res;
    u64_t trial;
    res = 0;
    for (int b = 23; b >= 0; b--) begin
      trial = res | (u64_t'(1) << b);
      if (trial * trial <= x) res = trial;
    end
    return res;
  endfunction

  // close a set: mean, clamped variance, deviation; clear the sums
  task automatic close_set();
    longint m;
    u64_t   msq;
    u64_t   mag;
    u64_t   variance;
    if (count_acc == '0) begin
      mean_val = '0;
      dev_val  = '0;
    end else begin
      m        = longint'(sum_acc) / longint'(count_acc);
      msq      = u64_t'(sq_acc) / u64_t'(count_acc);
      mag      = u64_t'(m < 0 ? -m : m);
      variance = (msq > mag * mag) ? msq - mag * mag : 0;
      mean_val = MEAN_W'(m);
      dev_val  = DEV_W'(root_floor(variance));
    end
    count_acc = '0;
    sum_acc   = '0;
    sq_acc    = '0;
  endtask

  // stretch one sample between mean -/+ k deviations
  function automatic level_beat_t stretch_level(input logic signed [SAMPLE_W-1:0] s,
                                                input logic lst);
    longint      span;
    longint      lo;
    longint      hi;
    longint      v;
    level_beat_t r;
    span = longint'(spread) * longint'(dev_val);
    lo   = longint'(mean_val) - span;
    hi   = longint'(mean_val) + span;
    v    = longint'(s);
    if (v <= lo) r.level = '0;
    else if (v >= hi) r.level = LEVEL_W'(LEVEL_TOP);
    else r.level = LEVEL_W'(((v - lo) * LEVEL_TOP) / (hi - lo));
    r.last_out = lst;
    return r;
  endfunction

  task automatic note_mismatch(input level_beat_t want, input string what);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("%0t: %s: expected level %0d last_out %0b, got level %0d last_out %0b",
               $time, what, want.level, want.last_out, out_ch.level, out_ch.last_out);
  endtask

  // watch the channels and the register port at each edge
  always @(posedge clk) begin
    level_beat_t want;
    u64_t        mag;
    if (rst) begin
      level_q.delete();
      spread    = SPREAD_RESET;
      count_acc = '0;
      sum_acc   = '0;
      sq_acc    = '0;
      mean_val  = '0;
      dev_val   = '0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_SPREAD_SIGMAS)
        spread = pwdata[K_W-1:0];

      // result beat against the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        if (level_q.size() == 0) begin
          want = '0;
          note_mismatch(want, "level beat with nothing expected");
        end else begin
          want = level_q.pop_front();
          if (want.level !== out_ch.level || want.last_out !== out_ch.last_out)
            note_mismatch(want, "level beat mismatch");
        end
      end

      // input beat updates the shadow state or queues a level
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.func == FUNC_CONVERT) begin
          level_q.push_back(stretch_level(in_ch.sample, in_ch.last));
        end else begin
          if (count_acc < COUNT_W'(MAX_SAMPLES)) begin
            mag       = u64_t'(in_ch.sample < 0 ? -longint'(in_ch.sample)
                                                : longint'(in_ch.sample));
            count_acc = count_acc + 1'b1;
            sum_acc   = sum_acc + in_ch.sample;
            sq_acc    = sq_acc + SQ_W'(mag * mag);
          end
          if (in_ch.last) close_set();
        end
      end
    end
    mismatches  <= fail_count;
    outstanding <= level_q.size();
  end

endmodule

// File: verif/sigma_clip_contrast_stretch_top_tb.sv
`timescale 1ns / 1ps

module sigma_clip_contrast_stretch_top_tb;
  import scs_pkg::*;

  localparam int RANDOM_ITEMS   = 1050;
  localparam int STALL_LIMIT    = 5000;
  localparam int SETTLE_CYCLES  = 150;
  localparam int IDLE_PCT       = 16;
  localparam int OVERFLOW_PHASE = 7;
  localparam int CALM_FIRST     = 6;
  localparam int CALM_LAST      = 8;
  localparam int SAMPLE_MAX     = 32767;
  localparam int SAMPLE_MIN     = -32768;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  scs_in_if  in_ch ();
  scs_out_if out_ch ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned stall_cycles;
  int unsigned random_items;
  bit          calm;

  sigma_clip_contrast_stretch_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  scs_level_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // watchdog on cycles without any beat or register access
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one input beat, with random idle cycles ahead of it
  task automatic send_beat(input logic f, input logic signed [SAMPLE_W-1:0] s,
                           input logic l);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.func   <= f;
    in_ch.sample <= s;
    in_ch.last   <= l;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // hold the sender until every level is back and the block has gone quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_spread(input logic [K_W-1:0] k);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SPREAD_SIGMAS, 2'b00};
    pwdata  <= DATA_W'(k);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // sample within +/- w of a centre, clipped to the Q1.15 range
  function automatic logic signed [SAMPLE_W-1:0] near(input logic signed [SAMPLE_W-1:0] c,
                                                      input int unsigned w);
    longint x;
    x = longint'(c) + longint'($urandom_range(2 * w, 0)) - longint'(w);
    if (x > SAMPLE_MAX) x = SAMPLE_MAX;
    if (x < SAMPLE_MIN) x = SAMPLE_MIN;
    return SAMPLE_W'(x);
  endfunction

  // extremes, empty statistics, zero deviation, known bounds
  task automatic directed_items();
    // conversions with no statistics yet
    send_beat(FUNC_CONVERT, SAMPLE_W'(SAMPLE_MIN), 1'b0);
    send_beat(FUNC_CONVERT, -16'sd1, 1'b0);
    send_beat(FUNC_CONVERT, 16'sd0, 1'b0);
    send_beat(FUNC_CONVERT, 16'sd1, 1'b0);
    send_beat(FUNC_CONVERT, SAMPLE_W'(SAMPLE_MAX), 1'b1);
    // mean 0, deviation 4: bounds at -8 and 8 with k of 2
    send_beat(FUNC_ACCUM, -16'sd4, 1'b0);
    send_beat(FUNC_ACCUM, 16'sd4, 1'b1);
    send_beat(FUNC_CONVERT, -16'sd8, 1'b0);
    send_beat(FUNC_CONVERT, -16'sd7, 1'b0);
    send_beat(FUNC_CONVERT, 16'sd0, 1'b0);
    send_beat(FUNC_CONVERT, 16'sd7, 1'b0);
    send_beat(FUNC_CONVERT, 16'sd8, 1'b0);
    send_beat(FUNC_CONVERT, SAMPLE_W'(SAMPLE_MIN), 1'b0);
    send_beat(FUNC_CONVERT, SAMPLE_W'(SAMPLE_MAX), 1'b1);
    // identical samples give zero deviation
    send_beat(FUNC_ACCUM, 16'sd100, 1'b0);
    send_beat(FUNC_ACCUM, 16'sd100, 1'b0);
    send_beat(FUNC_ACCUM, 16'sd100, 1'b1);
    send_beat(FUNC_CONVERT, 16'sd99, 1'b0);
    send_beat(FUNC_CONVERT, 16'sd100, 1'b0);
    send_beat(FUNC_CONVERT, 16'sd101, 1'b1);
    // widest variance
    send_beat(FUNC_ACCUM, SAMPLE_W'(SAMPLE_MIN), 1'b0);
    send_beat(FUNC_ACCUM, SAMPLE_W'(SAMPLE_MAX), 1'b1);
    send_beat(FUNC_CONVERT, SAMPLE_W'(SAMPLE_MIN), 1'b0);
    send_beat(FUNC_CONVERT, 16'sd0, 1'b0);
    send_beat(FUNC_CONVERT, SAMPLE_W'(SAMPLE_MAX), 1'b1);
  endtask

  // one set of statistics followed by conversions, or a burst of noise
  task automatic run_phase(input int idx);
    int unsigned              n_acc;
    int unsigned              n_cnv;
    int unsigned              width;
    logic signed [SAMPLE_W-1:0] centre;
    logic signed [SAMPLE_W-1:0] s;
    if (idx == CALM_FIRST) calm <= 1'b1;
    if (idx == CALM_LAST + 1) calm <= 1'b0;

    if (idx != OVERFLOW_PHASE && $urandom_range(7) == 0) begin
      // noise: mixed functions, stray last marks, full-range samples
      n_acc = $urandom_range(30, 8);
      for (int i = 0; i < n_acc; i++)
        send_beat(1'($urandom_range(1)), SAMPLE_W'($urandom), $urandom_range(3) == 0);
      random_items += n_acc;
      return;
    end

    centre = SAMPLE_W'($urandom);
    case ($urandom_range(3))
      0:       width = 0;
      1:       width = $urandom_range(64);
      2:       width = $urandom_range(4096);
      default: width = 32768;
    endcase
    if (idx == OVERFLOW_PHASE) n_acc = MAX_SAMPLES + 8;
    else if ($urandom_range(3) == 0) n_acc = $urandom_range(4, 1);
    else n_acc = $urandom_range(40, 5);

    // accumulate pass, last mark on the final sample
    for (int i = 0; i < n_acc; i++)
      send_beat(FUNC_ACCUM, near(centre, width), i == n_acc - 1);
    if (idx != OVERFLOW_PHASE) random_items += n_acc;

    // convert pass
    n_cnv = $urandom_range(30, 4);
    for (int i = 0; i < n_cnv; i++) begin
      case ($urandom_range(9))
        6, 7:    s = SAMPLE_W'($urandom);
        8:       s = centre;
        9:       s = $urandom_range(1) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(SAMPLE_MIN);
        default: s = near(centre, width * 3 + 4);
      endcase
      send_beat(FUNC_CONVERT, s, (i == n_cnv - 1) || ($urandom_range(7) == 0));
    end
    random_items += n_cnv;
  endtask

  // stimulus
  initial begin
    logic [K_W-1:0] opening_k [5];
    int             phase;
    opening_k = '{K_W'(8), K_W'(1), K_W'(0), K_W'(15), K_W'(2)};

    rst          <= 1'b1;
    in_ch.valid  <= 1'b0;
    in_ch.func   <= FUNC_ACCUM;
    in_ch.sample <= '0;
    in_ch.last   <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    calm         <= 1'b0;
    random_items = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_items();

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      // spread changes only with the block drained
      if (phase < 5 || $urandom_range(3) == 0) begin
        settle();
        write_spread(phase < 5 ? opening_k[phase] : K_W'($urandom_range(8, 1)));
      end
      run_phase(phase);
      phase++;
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/scs_pkg.sv
design/scs_in_if.sv
design/scs_out_if.sv
design/scs_iter_unit.sv
design/sigma_clip_contrast_stretch_top.sv
design/scs_checker.sv
verif/scs_level_checker.sv
verif/sigma_clip_contrast_stretch_top_tb.sv
